// ===== design/wrst_pkg.sv =====
// Shared types and constants for the weekly relay schedule table.
// Used by the match logic and the top level; depends on nothing.
package wrst_pkg;

  // Operation codes of a request.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Time constants.
  localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
  localparam logic [10:0] NO_MINUTE        = 11'h7FF;

  // One stored schedule entry, 27 bits.
  typedef struct packed {
    logic [7:0] id;
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       action;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of checking one stored entry against the current request.
  typedef struct packed {
    logic       tick_hit;
    logic       id_hit;
    logic [8:0] max_id_p1;
  } match_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD_WR,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } state_t;

endpackage

// ===== design/wrst_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module wrst_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/wrst_match.sv =====
// Compares one stored entry with the latched request during a table walk.
// Depends on wrst_pkg for the entry and match types.
module wrst_match (
  input  wrst_pkg::entry_t entry,
  input  logic [4:0]       hour,
  input  logic [5:0]       minute,
  input  logic [2:0]       wday,
  input  logic [7:0]       id,
  input  logic [8:0]       max_id_p1,
  output wrst_pkg::match_t result
);

  logic [7:0] days8;
  logic [8:0] id_p1;

  // The day mask has no bit for weekday seven, so that code never matches.
  assign days8 = {1'b0, entry.days};
  assign id_p1 = {1'b0, entry.id} + 9'd1;

  always_comb begin
    result.tick_hit  = days8[wday] && (entry.hour == hour) && (entry.minute == minute);
    result.id_hit    = (entry.id == id);
    result.max_id_p1 = (id_p1 > max_id_p1) ? id_p1 : max_id_p1;
  end

endmodule

// ===== design/weekly_relay_schedule_table_top.sv =====
// Top level of the weekly relay schedule table: sequencer, table RAM and result register.
// Depends on wrst_pkg, wrst_ram and wrst_match.

// The block takes one request at a time. Every add, remove and processed tick walks the
// stored entries through the single read port of the table RAM, one entry per cycle; a remove
// stops at the first matching id. A successful add or remove then writes one entry back,
// while a rejected add, an ignored tick or an unused operation skips the walk. A new
// request is taken as soon as the previous result sits in the output register, even while that
// result still waits to be collected. No clearing pass is needed after reset: only entries
// below the fill count are ever read.
module weekly_relay_schedule_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [4:0] in_hour_of_day,
  input  logic [5:0] in_minute_of_hour,
  input  logic [2:0] in_weekday,
  input  logic [6:0] in_day_mask,
  input  logic       in_relay_action,
  input  logic [7:0] in_entry_id,
  input  logic       in_clock_synced,
  input  logic       in_time_plausible,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_assigned_id,
  output logic       out_relay_write,
  output logic       out_relay_level
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  wrst_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          sync_r, sync_nxt;
  logic [10:0]   last_mod_r, last_mod_nxt;

  // Latched request fields.
  logic [1:0] op_r;
  logic [4:0] hour_r;
  logic [5:0] minute_r;
  logic [2:0] wday_r;
  logic [6:0] days_r;
  logic       action_r;
  logic [7:0] id_r;

  // Walk control and accumulated results.
  logic [CW-1:0] issue_r, issue_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [8:0]    max_p1_r, max_p1_nxt;
  logic          wr_r, wr_nxt;
  logic          level_r, level_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [7:0]    res_id_r, res_id_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [7:0] out_id_r, out_id_nxt;
  logic       out_wr_r, out_wr_nxt;
  logic       out_level_r, out_level_nxt;

  // Table RAM ports.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [AW-1:0]          ram_raddr;
  wrst_pkg::entry_t       ram_wdata;
  logic [wrst_pkg::ENTRY_W-1:0] ram_rdata;
  wrst_pkg::entry_t       rd_entry;
  wrst_pkg::match_t       match;

  logic        accept;
  logic        issue;
  logic        sync_eff;
  logic [10:0] mod_day;
  logic        tick_go;
  logic        full;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == wrst_pkg::ST_IDLE);
  assign rd_entry = wrst_pkg::entry_t'(ram_rdata);
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign issue    = (issue_r != count_r);

  // Tick gating from the live request fields.
  assign sync_eff = sync_r || in_clock_synced;
  assign mod_day  = {6'd0, in_hour_of_day} * wrst_pkg::MINUTES_PER_HOUR
                    + {5'd0, in_minute_of_hour};
  assign tick_go  = sync_eff && in_time_plausible && (mod_day != last_mod_r);

  wrst_ram #(
    .WIDTH(wrst_pkg::ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  wrst_match u_match (
    .entry    (rd_entry),
    .hour     (hour_r),
    .minute   (minute_r),
    .wday     (wday_r),
    .id       (id_r),
    .max_id_p1(max_p1_r),
    .result   (match)
  );

  // Sequencer: next state, walk control and RAM accesses.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sync_nxt       = sync_r;
    last_mod_nxt   = last_mod_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    hit_idx_nxt    = hit_idx_r;
    max_p1_nxt     = max_p1_r;
    wr_nxt         = wr_r;
    level_nxt      = level_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[AW-1:0];
    ram_raddr      = issue_r[AW-1:0];
    ram_wdata      = rd_entry;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_wr_nxt     = out_wr_r;
    out_level_nxt  = out_level_r;

    case (state_r)
      wrst_pkg::ST_IDLE: begin
        if (accept) begin
          issue_nxt      = '0;
          max_p1_nxt     = 9'd0;
          wr_nxt         = 1'b0;
          level_nxt      = 1'b0;
          res_status_nxt = wrst_pkg::STATUS_OK;
          res_id_nxt     = 8'd0;
          case (in_operation)
            wrst_pkg::OP_TICK: begin
              sync_nxt = sync_eff;
              if (tick_go) begin
                last_mod_nxt = mod_day;
                state_nxt    = wrst_pkg::ST_SCAN;
              end else begin
                state_nxt = wrst_pkg::ST_DONE;
              end
            end
            wrst_pkg::OP_ADD: begin
              if (full) begin
                res_status_nxt = wrst_pkg::STATUS_FULL;
                state_nxt      = wrst_pkg::ST_DONE;
              end else begin
                state_nxt = wrst_pkg::ST_SCAN;
              end
            end
            wrst_pkg::OP_REMOVE: begin
              res_status_nxt = wrst_pkg::STATUS_NOT_FOUND;
              state_nxt      = wrst_pkg::ST_SCAN;
            end
            default: begin
              state_nxt = wrst_pkg::ST_DONE;
            end
          endcase
        end
      end

      wrst_pkg::ST_SCAN: begin
        // Issue one read a cycle and judge the entry read in the cycle before.
        pend_nxt = issue;
        if (issue) begin
          issue_nxt = issue_r + CW'(1);
        end
        if (pend_r) begin
          case (op_r)
            wrst_pkg::OP_TICK: begin
              if (match.tick_hit) begin
                wr_nxt    = 1'b1;
                level_nxt = rd_entry.action;
              end
            end
            wrst_pkg::OP_ADD: begin
              max_p1_nxt = match.max_id_p1;
            end
            wrst_pkg::OP_REMOVE: begin
              if (match.id_hit) begin
                hit_idx_nxt    = pend_idx_r;
                res_status_nxt = wrst_pkg::STATUS_OK;
                state_nxt      = wrst_pkg::ST_MOVE_RD;
              end
            end
            default: begin
            end
          endcase
        end else if (!issue) begin
          if (op_r == wrst_pkg::OP_ADD) begin
            state_nxt = wrst_pkg::ST_ADD_WR;
          end else begin
            state_nxt = wrst_pkg::ST_DONE;
          end
        end
      end

      wrst_pkg::ST_ADD_WR: begin
        // Append the new entry behind the last one.
        ram_we           = 1'b1;
        ram_waddr        = count_r[AW-1:0];
        ram_wdata.id     = max_p1_r[7:0];
        ram_wdata.days   = days_r;
        ram_wdata.hour   = hour_r;
        ram_wdata.minute = minute_r;
        ram_wdata.action = action_r;
        res_id_nxt       = max_p1_r[7:0];
        count_nxt        = count_r + CW'(1);
        state_nxt        = wrst_pkg::ST_DONE;
      end

      wrst_pkg::ST_MOVE_RD: begin
        ram_raddr = AW'(count_r - CW'(1));
        state_nxt = wrst_pkg::ST_MOVE_WR;
      end

      wrst_pkg::ST_MOVE_WR: begin
        // The last entry fills the hole left by the removed one.
        ram_we    = 1'b1;
        ram_waddr = hit_idx_r;
        ram_wdata = rd_entry;
        count_nxt = count_r - CW'(1);
        state_nxt = wrst_pkg::ST_DONE;
      end

      wrst_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_wr_nxt     = wr_r;
          out_level_nxt  = level_r;
          state_nxt      = wrst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = wrst_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrst_pkg::ST_IDLE;
      count_r     <= '0;
      sync_r      <= 1'b0;
      last_mod_r  <= wrst_pkg::NO_MINUTE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sync_r      <= sync_nxt;
      last_mod_r  <= last_mod_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      hour_r   <= in_hour_of_day;
      minute_r <= in_minute_of_hour;
      wday_r   <= in_weekday;
      days_r   <= in_day_mask;
      action_r <= in_relay_action;
      id_r     <= in_entry_id;
    end
    issue_r      <= issue_nxt;
    pend_idx_r   <= issue_r[AW-1:0];
    hit_idx_r    <= hit_idx_nxt;
    max_p1_r     <= max_p1_nxt;
    wr_r         <= wr_nxt;
    level_r      <= level_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_wr_r     <= out_wr_nxt;
    out_level_r  <= out_level_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_id_r;
  assign out_relay_write = out_wr_r;
  assign out_relay_level = out_level_r;

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != wrst_pkg::ST_IDLE)
    else $error("request accepted without starting work");

  // A new result only appears from the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == wrst_pkg::ST_DONE))
    else $error("result raised outside the done state");

  // A remove write back shrinks the table by exactly one.
  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wrst_pkg::ST_MOVE_WR) |=> count_r == $past(count_r) - CW'(1))
    else $error("remove did not shrink the table");

  // An add that passes the fullness check grows the table by one.
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wrst_pkg::ST_ADD_WR) |=> count_r == $past(count_r) + CW'(1))
    else $error("add did not grow the table");

endmodule
